FILE: hdl/assert_macros.svh
// Assertion helpers included by the continuity filter unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define TPCF_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check that a condition implies another one on the next clock edge.
`define TPCF_ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
		else $error(msg);

`endif

FILE: hdl/tpcf_pkg.sv
package tpcf_pkg;

	localparam int PID_W = 13;
	localparam int PID_COUNT = 1 << PID_W;
	localparam int CC_W = 4;
	localparam int ALEN_W = 8;
	localparam int VERDICT_W = 3;
	localparam int OFFSET_W = 8;

	localparam logic [PID_W-1:0] NULL_PID = 13'h1FFF;
	// Largest adaptation length byte that still fits the packet
	localparam logic [ALEN_W-1:0] MAX_ADAPT_LEN = 8'd179;
	localparam logic [OFFSET_W-1:0] HEADER_BYTES = 8'd4;

	localparam logic [1:0] AFC_RESERVED = 2'd0;

	localparam logic [VERDICT_W-1:0] V_PAYLOAD    = 3'd0;
	localparam logic [VERDICT_W-1:0] V_NO_PAYLOAD = 3'd1;
	localparam logic [VERDICT_W-1:0] V_ERROR      = 3'd2;
	localparam logic [VERDICT_W-1:0] V_DUPLICATE  = 3'd3;
	localparam logic [VERDICT_W-1:0] V_RESERVED   = 3'd4;
	localparam logic [VERDICT_W-1:0] V_BAD_ADAPT  = 3'd5;
	localparam logic [VERDICT_W-1:0] V_NULL_PID   = 3'd6;

	typedef struct packed {
		logic            started;
		logic [CC_W-1:0] last_count;
	} pid_entry_t;

	typedef struct packed {
		logic             en;
		logic [PID_W-1:0] addr;
		pid_entry_t       data;
	} tbl_wr_t;

endpackage

FILE: hdl/ts_pid_continuity_filter_unit.sv
// Transport stream continuity filter: takes one packet header per transfer and
// returns one verdict per header, in order. Each of the 8192 PIDs has a started
// flag and its last continuity count in an on-chip table with a registered
// read. A header is read from the table when it is taken, classified in the
// next cycle from stage 1, and its entry is written back as it leaves stage 1;
// a header that follows right behind one of the same PID picks up the new
// entry through a bypass, so the block takes one header per clock while the
// verdict channel does not stall. Verdicts wait in the output register, which
// lets a new header enter while a verdict still waits. After reset the block
// sweeps the table clear, one entry per clock, and holds hdr_ready low until
// the sweep ends. Verdicts: 0 payload (payload_offset gives its byte offset),
// 1 no payload, 2 transport error (table untouched), 3 duplicate, 4 reserved
// adaptation control, 5 adaptation length over 179, 6 null PID. Every header
// without the error bit updates its PID's entry, even when it is dropped.
`include "assert_macros.svh"

module ts_pid_continuity_filter_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	// header channel
	input  logic                          hdr_valid,
	output logic                          hdr_ready,
	input  logic [tpcf_pkg::PID_W-1:0]    pid,
	input  logic                          transport_error,
	input  logic [1:0]                    adaptation_control,
	input  logic [tpcf_pkg::CC_W-1:0]     continuity,
	input  logic [tpcf_pkg::ALEN_W-1:0]   adaptation_length,
	input  logic                          discontinuity,
	// verdict channel
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic [tpcf_pkg::VERDICT_W-1:0] verdict,
	output logic [tpcf_pkg::OFFSET_W-1:0]  payload_offset,
	output logic                          count_gap,
	output logic                          first_seen
);

	// Stage 1: header held while the table read completes
	logic                          valid_s1;
	logic [tpcf_pkg::PID_W-1:0]    pid_s1;
	logic                          terr_s1;
	logic [1:0]                    afc_s1;
	logic [tpcf_pkg::CC_W-1:0]     cc_s1;
	logic [tpcf_pkg::ALEN_W-1:0]   alen_s1;
	logic                          disc_s1;
	logic                          fwd_hit_s1;
	tpcf_pkg::pid_entry_t          fwd_data_s1;

	// Output register
	logic                          res_valid_q;
	logic [tpcf_pkg::VERDICT_W-1:0] verdict_q;
	logic [tpcf_pkg::OFFSET_W-1:0]  offset_q;
	logic                          gap_q;
	logic                          first_q;

	logic                          hdr_xfer;
	logic                          adv_s1;
	logic                          tbl_busy;
	tpcf_pkg::pid_entry_t          rd_entry;
	tpcf_pkg::pid_entry_t          cur_entry;
	tpcf_pkg::tbl_wr_t             tbl_wr;
	logic                          fwd_match;

	logic                          is_first;
	logic                          has_adapt;
	logic                          same_cc;
	logic                          next_cc;
	logic                          is_dup;
	logic                          is_gap;
	logic [tpcf_pkg::VERDICT_W-1:0] verdict_d;
	logic [tpcf_pkg::OFFSET_W-1:0]  offset_d;

	logic                          offset_ok;
	logic                          err_with_gap;

	assign adv_s1    = valid_s1 && (!res_valid_q || res_ready);
	assign hdr_ready = !tbl_busy && (!valid_s1 || adv_s1);
	assign hdr_xfer  = hdr_valid && hdr_ready;

	tpcf_pid_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (hdr_xfer),
		.rd_addr (pid),
		.rd_data (rd_entry),
		.wr      (tbl_wr),
		.busy    (tbl_busy)
	);

	// Bypass the entry written in the cycle this header's read was issued
	assign fwd_match = tbl_wr.en && (tbl_wr.addr == pid);
	assign cur_entry = fwd_hit_s1 ? fwd_data_s1 : rd_entry;

	always_comb begin
		is_first  = !cur_entry.started;
		has_adapt = afc_s1[1];
		same_cc   = cur_entry.last_count == cc_s1;
		next_cc   = (cur_entry.last_count + 1'b1) == cc_s1;
		// a repeat passes only on a signalled discontinuity
		is_dup    = !is_first && same_cc &&
			!(has_adapt && (alen_s1 != '0) && disc_s1);
		is_gap    = !terr_s1 && !is_first && !same_cc && !next_cc;
		offset_d  = '0;

		if (terr_s1) begin
			verdict_d = tpcf_pkg::V_ERROR;
		end else if (afc_s1 == tpcf_pkg::AFC_RESERVED) begin
			verdict_d = tpcf_pkg::V_RESERVED;
		end else if (has_adapt && (alen_s1 > tpcf_pkg::MAX_ADAPT_LEN)) begin
			verdict_d = tpcf_pkg::V_BAD_ADAPT;
		end else if (is_dup) begin
			verdict_d = tpcf_pkg::V_DUPLICATE;
		end else if (pid_s1 == tpcf_pkg::NULL_PID) begin
			verdict_d = tpcf_pkg::V_NULL_PID;
		end else if (afc_s1[0]) begin
			verdict_d = tpcf_pkg::V_PAYLOAD;
			// length is at most 179 here, so the sum stays within 8 bits
			offset_d  = has_adapt ? tpcf_pkg::HEADER_BYTES + alen_s1 + 1'b1
				: tpcf_pkg::HEADER_BYTES;
		end else begin
			verdict_d = tpcf_pkg::V_NO_PAYLOAD;
		end

		// write back once, as the header leaves stage 1; error headers leave the entry
		tbl_wr.en                 = adv_s1 && !terr_s1;
		tbl_wr.addr               = pid_s1;
		tbl_wr.data.started       = 1'b1;
		tbl_wr.data.last_count    = cc_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (hdr_xfer) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: load on transfer, hold while stalled
	always_ff @(posedge clk) begin
		if (hdr_xfer) begin
			pid_s1      <= pid;
			terr_s1     <= transport_error;
			afc_s1      <= adaptation_control;
			cc_s1       <= continuity;
			alen_s1     <= adaptation_length;
			disc_s1     <= discontinuity;
			fwd_hit_s1  <= fwd_match;
			fwd_data_s1 <= tbl_wr.data;
		end
		if (adv_s1) begin
			verdict_q <= verdict_d;
			offset_q  <= offset_d;
			gap_q     <= is_gap;
			first_q   <= is_first;
		end
	end

	assign res_valid      = res_valid_q;
	assign verdict        = verdict_q;
	assign payload_offset = offset_q;
	assign count_gap      = gap_q;
	assign first_seen     = first_q;

	assign offset_ok    = !res_valid_q || (verdict_q == tpcf_pkg::V_PAYLOAD) || (offset_q == '0);
	assign err_with_gap = res_valid_q && (verdict_q == tpcf_pkg::V_ERROR) && gap_q;

	`TPCF_ASSERT(a_wr_on_adv, clk, arst_n, !tbl_wr.en || adv_s1, "table write outside advance")
	`TPCF_ASSERT(a_no_xfer_busy, clk, arst_n, !(hdr_xfer && tbl_busy), "header taken during sweep")
	`TPCF_ASSERT_NEXT(a_fwd, clk, arst_n, hdr_xfer && fwd_match, fwd_hit_s1, "bypass missed")
	`TPCF_ASSERT(a_offset, clk, arst_n, offset_ok, "offset without payload")
	`TPCF_ASSERT(a_err_gap, clk, arst_n, !err_with_gap, "gap on error")

endmodule

FILE: hdl/tpcf_pid_table.sv
// Per-PID continuity table: one write and one registered read per cycle.
// Sweep every entry to zero after reset; hold busy until the sweep ends.
module tpcf_pid_table (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rd_en,
	input  logic [tpcf_pkg::PID_W-1:0] rd_addr,
	output tpcf_pkg::pid_entry_t      rd_data,
	input  tpcf_pkg::tbl_wr_t         wr,
	output logic                      busy
);

	tpcf_pkg::pid_entry_t mem [tpcf_pkg::PID_COUNT];
	tpcf_pkg::pid_entry_t rd_data_q;
	logic [tpcf_pkg::PID_W-1:0] clr_addr_q;
	logic busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b1;
			clr_addr_q <= '0;
		end else if (busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (&clr_addr_q) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_addr_q] <= '0;
		end else if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
	assign busy    = busy_q;

endmodule
